// ----- design/psrp_pkg.sv -----
// Shared types and constants of the performance-sample record parser.
package psrp_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int COUNT_W = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [COUNT_W-1:0] FIRST_ENTRY_POS   = 13'd5;
   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 13'd127;

   // Reciprocal of three for values below 2^16: floor(n / 3) = (n * 43691) >> 17.
   localparam logic [15:0] THIRD_RECIP = 16'd43691;
   localparam int          THIRD_SHIFT = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_LBR_MODE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ENTRIES = 1'b1;

   typedef enum logic [2:0] {
      KIND_HEADER,
      KIND_IP,
      KIND_PIDTID,
      KIND_TIMESTAMP,
      KIND_COUNT,
      KIND_ENTRY
   } word_kind_type;

   typedef struct packed {
      logic                lbr_mode;
      logic [COUNT_W-1:0]  max_entries;
   } cfg_type;

   typedef struct packed {
      word_kind_type       kind;
      logic                present;
      logic                record_end;
      logic [WORD_W-1:0]   word;
   } work_item_type;

endpackage

// ----- design/psrp_req_if.sv -----
// Input channel carrying record stream words.
interface psrp_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- design/psrp_rsp_if.sv -----
// Result channel carrying parsed sample fields and entries.
interface psrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] sample_ip;
   logic [31:0] pid;
   logic [31:0] tid;
   logic [63:0] timestamp;
   logic [63:0] entry_addr;
   logic        entry_present;
   logic [12:0] entry_count;
   logic        record_end;

   modport source (output valid, output sample_ip, output pid, output tid,
                   output timestamp, output entry_addr, output entry_present,
                   output entry_count, output record_end, input ready);
   modport sink (input valid, input sample_ip, input pid, input tid,
                 input timestamp, input entry_addr, input entry_present,
                 input entry_count, input record_end, output ready);
endinterface

// ----- design/psrp_front.sv -----
// Front end: tracks the word position in a record and classifies each word.
module psrp_front
   import psrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   psrp_req_if.sink      req_ch,
   input  logic          push_ready,
   output logic          push_valid,
   output work_item_type push_item
);

   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic [COUNT_W-1:0] words_ff, words_in;
   logic [COUNT_W-1:0] fit3_ff, fit3_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [1:0]         sub3_ff, sub3_in;
   logic [COUNT_W-1:0] grp_ff, grp_in;

   logic               accept;
   logic [COUNT_W-1:0] hdr_words;
   logic [COUNT_W-1:0] words_cur;
   logic [COUNT_W-1:0] rem;
   logic [28:0]        third_prod;
   logic [COUNT_W-1:0] fit;
   logic [COUNT_W-1:0] lim;
   logic [COUNT_W-1:0] idx;
   logic               record_end;
   logic               present;
   word_kind_type      kind;

   assign accept       = req_ch.valid && push_ready;
   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;

   assign hdr_words = (req_ch.word[63:51] == 13'd0) ? 13'd1 : req_ch.word[63:51];
   assign words_cur = (pos_ff == '0) ? hdr_words : words_ff;
   assign rem       = (words_ff > FIRST_ENTRY_POS) ? (words_ff - FIRST_ENTRY_POS) : '0;
   assign third_prod = {16'd0, rem} * {13'd0, THIRD_RECIP};
   assign fit3_in   = {1'b0, third_prod[28:THIRD_SHIFT]};
   assign idx       = pos_ff - FIRST_ENTRY_POS;

   always_comb begin
      fit = cfg.lbr_mode ? fit3_ff : rem;
      if ((req_ch.word[63:13] == 51'd0) && (req_ch.word[12:0] < fit)) begin
         lim = req_ch.word[12:0];
      end else begin
         lim = fit;
      end
      if (lim > cfg.max_entries) begin
         lim = cfg.max_entries;
      end
   end

   always_comb begin
      kind    = KIND_ENTRY;
      present = 1'b0;
      unique case (pos_ff)
         13'd0: kind = KIND_HEADER;
         13'd1: kind = KIND_IP;
         13'd2: kind = KIND_PIDTID;
         13'd3: kind = KIND_TIMESTAMP;
         13'd4: kind = KIND_COUNT;
         default: begin
            kind = KIND_ENTRY;
            if (cfg.lbr_mode) begin
               present = (sub3_ff == 2'd0) && (grp_ff < limit_ff)
                         && (req_ch.word != 64'd0);
            end else begin
               present = idx < limit_ff;
            end
         end
      endcase
   end

   assign record_end = ({1'b0, pos_ff} + 14'd1) >= {1'b0, words_cur};

   always_comb begin
      pos_in   = pos_ff;
      words_in = words_ff;
      limit_in = limit_ff;
      sub3_in  = sub3_ff;
      grp_in   = grp_ff;
      if (accept) begin
         pos_in = record_end ? '0 : (pos_ff + 13'd1);
         if (kind == KIND_HEADER) begin
            words_in = hdr_words;
            limit_in = '0;
         end
         if (kind == KIND_COUNT) begin
            limit_in = lim;
            sub3_in  = 2'd0;
            grp_in   = '0;
         end
         if (kind == KIND_ENTRY) begin
            if (sub3_ff == 2'd2) begin
               sub3_in = 2'd0;
               grp_in  = grp_ff + 13'd1;
            end else begin
               sub3_in = sub3_ff + 2'd1;
            end
         end
      end
   end

   assign push_item.kind       = kind;
   assign push_item.present    = present;
   assign push_item.record_end = record_end;
   assign push_item.word       = req_ch.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         words_ff <= '0;
         limit_ff <= '0;
         sub3_ff  <= '0;
         grp_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         words_ff <= words_in;
         limit_ff <= limit_in;
         sub3_ff  <= sub3_in;
         grp_ff   <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      fit3_ff <= fit3_in;
   end

`ifndef NO_ASSERTIONS
   a_pos_inside_record: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (pos_ff < words_ff))
      else $error("Word position ran past the record length.");

   a_sub3_range: assert property (@(posedge clock) disable iff (reset)
      sub3_ff != 2'd3)
      else $error("Branch word phase left its range.");
`endif

endmodule

// ----- design/psrp_queue.sv -----
// Short queue of classified words between the front and back ends.
module psrp_queue
   import psrp_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  work_item_type push_item,
   output logic          push_ready,
   output logic          head_valid,
   output work_item_type head_item,
   input  logic          pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   work_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("Queue fill count exceeds its depth.");
`endif

endmodule

// ----- design/psrp_back.sv -----
// Back end: holds the header fields, counts kept entries and drives results.
module psrp_back
   import psrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  work_item_type head_item,
   output logic          pop,
   psrp_rsp_if.source    rsp_ch
);

   logic [WORD_W-1:0]  ip_ff, ip_in;
   logic [HALF_W-1:0]  pid_ff, pid_in;
   logic [HALF_W-1:0]  tid_ff, tid_in;
   logic [WORD_W-1:0]  ts_ff, ts_in;
   logic [COUNT_W-1:0] kept_ff, kept_in;
   logic               out_valid_ff, out_valid_in;

   logic [WORD_W-1:0]  o_ip_ff, o_ts_ff, o_addr_ff;
   logic [HALF_W-1:0]  o_pid_ff, o_tid_ff;
   logic [COUNT_W-1:0] o_count_ff;
   logic               o_present_ff, o_end_ff;

   logic               emit;

   assign pop  = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign emit = head_item.present || head_item.record_end;

   always_comb begin
      ip_in   = ip_ff;
      pid_in  = pid_ff;
      tid_in  = tid_ff;
      ts_in   = ts_ff;
      kept_in = kept_ff;
      unique case (head_item.kind)
         KIND_HEADER: begin
            ip_in   = '0;
            pid_in  = '0;
            tid_in  = '0;
            ts_in   = '0;
            kept_in = '0;
         end
         KIND_IP: ip_in = head_item.word;
         KIND_PIDTID: begin
            pid_in = head_item.word[31:0];
            tid_in = head_item.word[63:32];
         end
         KIND_TIMESTAMP: ts_in = head_item.word;
         KIND_COUNT: kept_in = kept_ff;
         KIND_ENTRY: begin
            if (head_item.present) begin
               kept_in = kept_ff + 13'd1;
            end
         end
         default: kept_in = kept_ff;
      endcase
   end

   assign out_valid_in = (pop && emit) || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff        <= '0;
         pid_ff       <= '0;
         tid_ff       <= '0;
         ts_ff        <= '0;
         kept_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            ip_ff   <= ip_in;
            pid_ff  <= pid_in;
            tid_ff  <= tid_in;
            ts_ff   <= ts_in;
            kept_ff <= kept_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         o_ip_ff      <= ip_in;
         o_pid_ff     <= pid_in;
         o_tid_ff     <= tid_in;
         o_ts_ff      <= ts_in;
         o_addr_ff    <= head_item.present ? head_item.word : '0;
         o_present_ff <= head_item.present;
         o_count_ff   <= kept_in;
         o_end_ff     <= head_item.record_end;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.sample_ip     = o_ip_ff;
   assign rsp_ch.pid           = o_pid_ff;
   assign rsp_ch.tid           = o_tid_ff;
   assign rsp_ch.timestamp     = o_ts_ff;
   assign rsp_ch.entry_addr    = o_addr_ff;
   assign rsp_ch.entry_present = o_present_ff;
   assign rsp_ch.entry_count   = o_count_ff;
   assign rsp_ch.record_end    = o_end_ff;

`ifndef NO_ASSERTIONS
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (o_present_ff || o_end_ff))
      else $error("Result shown without an entry or a record end.");

   a_absent_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !o_present_ff) |-> (o_addr_ff == '0))
      else $error("Entry address is nonzero on a result without an entry.");
`endif

endmodule

// ----- design/perf_sample_record_parser.sv -----
// Top level of the performance-sample record parser.
// The parser takes one 64-bit record word per clock cycle while the queue has room, and
// issues at most one result per word; a word and its result pass through two registers
// in order, the classified-word queue and then the result register. Throughput is limited
// only by back pressure on the result channel, which the queue of QUEUE_DEPTH entries
// absorbs before the input channel stalls. The entry limit is fixed when the count word
// arrives, using the configuration registers as they are at that moment.
module perf_sample_record_parser
   import psrp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                    clock,
   input  logic                    reset,
   psrp_req_if.sink                req_ch,
   psrp_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          push_ready;
   logic          push_valid;
   work_item_type push_item;
   logic          head_valid;
   work_item_type head_item;
   logic          pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LBR_MODE:    cfg_in.lbr_mode    = csr_wdata[0];
            CSR_MAX_ENTRIES: cfg_in.max_entries = csr_wdata[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lbr_mode    <= 1'b0;
         cfg_ff.max_entries <= MAX_ENTRIES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   psrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   psrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
